FILE: hdl/deqe_pkg.sv
// Shared types and constants for the double-ended queue engine.
// Holds the request and result word formats, request and status codes,
// the controller state type and the controller/datapath command structs.
package deqe_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WORD_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 8;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] push_value;
  } deqe_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] read_value;
    logic [OCC_W-1:0]         occupancy;
  } deqe_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } deqe_state_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic load_out;
  } deqe_cmd_t;

  typedef struct packed {
    logic out_busy;
  } deqe_sts_t;

endpackage

FILE: hdl/deqe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module deqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/deqe_ctrl.sv
// Controller state machine for the double-ended queue engine.
// Uses deqe_pkg for the state type and the command and status structs.
module deqe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  deqe_pkg::deqe_sts_t sts,
  output deqe_pkg::deqe_cmd_t cmd
);

  deqe_pkg::deqe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deqe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      deqe_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = deqe_pkg::S_EXEC;
        end
      end
      deqe_pkg::S_EXEC: begin
        state_next = deqe_pkg::S_LOAD;
      end
      deqe_pkg::S_LOAD: begin
        if (!sts.out_busy) begin
          state_next = deqe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deqe_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall    = 1'b1;
    cmd.take     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      deqe_pkg::S_IDLE: begin
        req_stall = 1'b0;
        cmd.take  = req_valid;
      end
      deqe_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      deqe_pkg::S_LOAD: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: hdl/deqe_dpath.sv
// Datapath of the double-ended queue engine: request register, ring
// pointers, word store and result register. Uses deqe_pkg and deqe_ram.
module deqe_dpath #(
  parameter int DEPTH = deqe_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  deqe_pkg::deqe_cmd_t cmd,
  output deqe_pkg::deqe_sts_t sts,
  input  deqe_pkg::deqe_req_t req,
  output logic                res_valid,
  input  logic                res_stall,
  output deqe_pkg::deqe_res_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deqe_pkg::deqe_req_t req_q;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [deqe_pkg::STAT_W-1:0] stat_q, stat_next;
  logic rd_use_q, rd_use_next;

  logic empty, full;
  logic [AW-1:0] head_dec, head_inc, tail_slot, back_slot;
  logic [AW:0] tail_sum, back_sum;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [deqe_pkg::WORD_W-1:0] rdata;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // Both sums stay below twice the depth, so one subtract wraps them.
  assign tail_sum  = {1'b0, head} + (AW+1)'(count);
  assign back_sum  = {1'b0, head} + (AW+1)'(count - 1'b1);
  assign tail_slot = (tail_sum >= (AW+1)'(DEPTH)) ?
                     AW'(tail_sum - (AW+1)'(DEPTH)) : tail_sum[AW-1:0];
  assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ?
                     AW'(back_sum - (AW+1)'(DEPTH)) : back_sum[AW-1:0];

  always_comb begin
    head_next   = head;
    count_next  = count;
    stat_next   = deqe_pkg::ST_OK;
    rd_use_next = 1'b0;
    we          = 1'b0;
    waddr       = head;
    re          = 1'b0;
    raddr       = head;
    case (req_q.req_type)
      deqe_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          stat_next = deqe_pkg::ST_FULL;
        end else begin
          we         = cmd.exec;
          waddr      = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      deqe_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          stat_next = deqe_pkg::ST_FULL;
        end else begin
          we         = cmd.exec;
          waddr      = tail_slot;
          count_next = count + 1'b1;
        end
      end
      deqe_pkg::REQ_POP_FRONT, deqe_pkg::REQ_PEEK_FRONT: begin
        if (empty) begin
          stat_next = deqe_pkg::ST_EMPTY;
        end else begin
          re          = cmd.exec;
          raddr       = head;
          rd_use_next = 1'b1;
          if (req_q.req_type == deqe_pkg::REQ_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
      end
      deqe_pkg::REQ_POP_BACK, deqe_pkg::REQ_PEEK_BACK: begin
        if (empty) begin
          stat_next = deqe_pkg::ST_EMPTY;
        end else begin
          re          = cmd.exec;
          raddr       = back_slot;
          rd_use_next = 1'b1;
          if (req_q.req_type == deqe_pkg::REQ_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      deqe_pkg::REQ_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
        stat_next = deqe_pkg::ST_OK;
      end
    endcase
  end

  deqe_ram #(
    .WIDTH(deqe_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req_q.push_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      stat_q   <= stat_next;
      rd_use_q <= rd_use_next;
    end
    if (cmd.load_out) begin
      res.status     <= stat_q;
      res.read_value <= rd_use_q ? $signed(rdata) : '0;
      res.occupancy  <= deqe_pkg::OCC_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head  <= head_next;
        count <= count_next;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign sts.out_busy = res_valid && res_stall;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("word count exceeds the ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(DEPTH - 1))
    else $error("head pointer outside the ring");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(res_valid && res_stall))
    else $error("result register loaded while a stalled word waits");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (count == $past(count) || count == $past(count) + 1'b1 ||
                  count == $past(count) - 1'b1 || count == '0))
    else $error("word count moved by more than one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> (count == $past(count) && head == $past(head)))
    else $error("ring state changed outside execution");
`endif

endmodule

FILE: hdl/double_ended_queue_engine.sv
// Double-ended queue engine of signed 32-bit words on a ring buffer.
// Request channel: req_valid / req_stall with a deqe_req_t word (request code
// and push data). Result channel: res_valid / res_stall with a deqe_res_t
// word (status, popped or peeked data, occupancy after the request).
// Every request gives exactly one result word, in request order.
// The result word is built in steps once the request is accepted: the
// accepting edge registers the request, the execute state updates the ring
// pointers and reads the store, and the load state captures the
// registered read port of the store into the result register.
// One request is in flight at a time and the controller steps through its
// three states (idle, execute, load) for each one, so a new request is taken
// only once the last is through. The next request is accepted while a finished result still waits.
// If the receiver stalls, the result register holds its word and the engine
// waits in its last step before taking the result of a further request.
// A synchronous reset empties the queue (head and count to zero), returns the
// controller to idle and clears res_valid; the word store itself is not
// cleared and needs no sweep.
module double_ended_queue_engine #(
  parameter int DEPTH = deqe_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  deqe_pkg::deqe_req_t req,
  output logic                res_valid,
  input  logic                res_stall,
  output deqe_pkg::deqe_res_t res
);

  deqe_pkg::deqe_cmd_t cmd;
  deqe_pkg::deqe_sts_t sts;

  deqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  deqe_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

FILE: tb/tb_double_ended_queue_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue engine: directed requests, a fill to
// capacity, then random traffic with sender gaps and receiver stalls, all scored in order.
// Depends directly on deqe_pkg and double_ended_queue_engine.
module tb_double_ended_queue_engine;

  localparam int DEPTH = deqe_pkg::DEPTH_DEF;
  localparam logic [deqe_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int TOTAL_WORDS = 950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;
  localparam int EXP_DEPTH = 64;
  localparam int DIRECTED_MAX = 32;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  typedef struct packed {
    deqe_pkg::deqe_req_t word;
    logic                typed;
    deqe_pkg::deqe_res_t answer;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  deqe_pkg::deqe_req_t req;
  logic                res_valid;
  logic                res_stall = 1'b0;
  deqe_pkg::deqe_res_t res;

  // Predictor state: a ring of words with a head pointer and an occupancy count.
  logic [deqe_pkg::WORD_W-1:0] ring_mem [DEPTH];
  int ring_head = 0;
  int ring_count = 0;

  // Expected results wait in a small ring, written on acceptance and read on each result.
  deqe_pkg::deqe_res_t exp_store [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;

  directed_row_t directed_rows [DIRECTED_MAX];
  int directed_count = 0;

  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int peak_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int idle_cycles = 0;
  logic [31:0] rx_cycle = '0;

  double_ended_queue_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #4 clk = ~clk;

  function automatic int results_pending();
    return exp_wr - exp_rd;
  endfunction

  function automatic deqe_pkg::deqe_res_t deque_apply(input deqe_pkg::deqe_req_t w);
    deqe_pkg::deqe_res_t r;
    int slot;
    r = '0;
    r.status = deqe_pkg::ST_OK;
    case (w.req_type)
      deqe_pkg::REQ_PUSH_FRONT, deqe_pkg::REQ_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = deqe_pkg::ST_FULL;
          full_rejects++;
        end else if (w.req_type == deqe_pkg::REQ_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = w.push_value;
          ring_count++;
        end else begin
          ring_mem[(ring_head + ring_count) % DEPTH] = w.push_value;
          ring_count++;
        end
      end
      deqe_pkg::REQ_POP_FRONT, deqe_pkg::REQ_PEEK_FRONT,
      deqe_pkg::REQ_POP_BACK, deqe_pkg::REQ_PEEK_BACK: begin
        if (ring_count == 0) begin
          r.status = deqe_pkg::ST_EMPTY;
          empty_rejects++;
        end else begin
          if (w.req_type == deqe_pkg::REQ_POP_FRONT || w.req_type == deqe_pkg::REQ_PEEK_FRONT)
            slot = ring_head;
          else
            slot = (ring_head + ring_count - 1) % DEPTH;
          r.read_value = ring_mem[slot];
          if (w.req_type == deqe_pkg::REQ_POP_FRONT)
            ring_head = (ring_head + 1) % DEPTH;
          if (w.req_type == deqe_pkg::REQ_POP_FRONT || w.req_type == deqe_pkg::REQ_POP_BACK)
            ring_count--;
        end
      end
      deqe_pkg::REQ_CLEAR: begin
        ring_count = 0;
        ring_head = 0;
      end
      default: ;
    endcase
    r.occupancy = deqe_pkg::OCC_W'(ring_count);
    if (ring_count > peak_count)
      peak_count = ring_count;
    return r;
  endfunction

  function automatic logic [deqe_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic deqe_pkg::deqe_req_t random_request(input traffic_mix_t mix);
    deqe_pkg::deqe_req_t w;
    int unsigned roll;
    int unsigned push_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: push_pct = 70;
      MIX_DRAIN: push_pct = 15;
      default: push_pct = 42;
    endcase
    w.push_value = random_word();
    if (roll < push_pct) begin
      w.req_type = $urandom_range(0, 1) ? deqe_pkg::REQ_PUSH_BACK : deqe_pkg::REQ_PUSH_FRONT;
    end else if (roll < 96) begin
      case ($urandom_range(0, 5))
        0, 1: w.req_type = deqe_pkg::REQ_POP_FRONT;
        2, 3: w.req_type = deqe_pkg::REQ_POP_BACK;
        4: w.req_type = deqe_pkg::REQ_PEEK_FRONT;
        default: w.req_type = deqe_pkg::REQ_PEEK_BACK;
      endcase
    end else if (roll < 98) begin
      w.req_type = deqe_pkg::REQ_CLEAR;
    end else begin
      w.req_type = REQ_UNUSED;
    end
    return w;
  endfunction

  task automatic add_directed(input logic [deqe_pkg::REQ_W-1:0] code,
                              input logic [deqe_pkg::WORD_W-1:0] value,
                              input bit typed, input logic [deqe_pkg::STAT_W-1:0] status,
                              input logic [deqe_pkg::WORD_W-1:0] rd, input int occ);
    directed_row_t row;
    row.word.req_type = code;
    row.word.push_value = value;
    row.typed = typed;
    row.answer.status = status;
    row.answer.read_value = rd;
    row.answer.occupancy = deqe_pkg::OCC_W'(occ);
    directed_rows[directed_count] = row;
    directed_count++;
  endtask

  // Holds the word until the engine takes it, then queues the expected result.
  task automatic send_word(input deqe_pkg::deqe_req_t w, input bit typed,
                           input deqe_pkg::deqe_res_t answer);
    deqe_pkg::deqe_res_t predicted;
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = deque_apply(w);
    exp_store[exp_wr % EXP_DEPTH] = typed ? answer : predicted;
    exp_wr++;
    words_sent++;
  endtask

  // Called right after an accepted word: keeps the burst going, inserts a gap,
  // or holds off until every expected result has come back.
  task automatic pace(input bit drain);
    if (drain || (gaps_on && burst_left == 0)) begin
      req_valid <= 1'b0;
      @(posedge clk);
      if (drain)
        while (results_pending() != 0) @(posedge clk);
      else
        repeat ($urandom_range(0, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic check_result(input deqe_pkg::deqe_res_t got);
    deqe_pkg::deqe_res_t want;
    results_seen++;
    if (results_pending() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected result word: status %0d value %h occupancy %0d",
                 got.status, got.read_value, got.occupancy);
    end else begin
      want = exp_store[exp_rd % EXP_DEPTH];
      exp_rd++;
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: status exp %0d got %0d, value exp %h got %h, occ exp %0d got %0d",
                   results_seen, want.status, got.status, want.read_value, got.read_value,
                   want.occupancy, got.occupancy);
      end
    end
  endtask

  // Receiver with its own stall pattern, result checking and the watchdog.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: res_stall <= 1'b0;
      2'd1: res_stall <= (rx_cycle % 3 == 0);
      2'd2: res_stall <= ($urandom_range(0, 1) != 0);
      default: res_stall <= rx_cycle[3];
    endcase
    if (!rst && res_valid && !res_stall)
      check_result(res);
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, results_pending());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    traffic_mix_t mix;
    int seg_len;
    deqe_pkg::deqe_req_t w;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;

    // Empty queue, both extremes of the data word, every end, unused code and clear.
    add_directed(deqe_pkg::REQ_POP_FRONT, 32'h0000_0000, 1'b1, deqe_pkg::ST_EMPTY, 32'h0, 0);
    add_directed(deqe_pkg::REQ_POP_BACK, 32'hFFFF_FFFF, 1'b1, deqe_pkg::ST_EMPTY, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PEEK_FRONT, 32'h0000_0000, 1'b1, deqe_pkg::ST_EMPTY, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PEEK_BACK, 32'h0000_0000, 1'b1, deqe_pkg::ST_EMPTY, 32'h0, 0);
    add_directed(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, deqe_pkg::ST_OK, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, deqe_pkg::ST_OK, 32'h0, 1);
    add_directed(deqe_pkg::REQ_PUSH_BACK, 32'h8000_0000, 1'b1, deqe_pkg::ST_OK, 32'h0, 2);
    add_directed(deqe_pkg::REQ_PEEK_FRONT, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h7FFF_FFFF, 2);
    add_directed(deqe_pkg::REQ_PEEK_BACK, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h8000_0000, 2);
    add_directed(deqe_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, deqe_pkg::ST_OK, 32'h0, 3);
    add_directed(deqe_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1'b1, deqe_pkg::ST_OK, 32'h0, 4);
    add_directed(deqe_pkg::REQ_POP_FRONT, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'hFFFF_FFFF, 3);
    add_directed(deqe_pkg::REQ_POP_BACK, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h0000_0000, 2);
    add_directed(deqe_pkg::REQ_POP_BACK, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h8000_0000, 1);
    add_directed(REQ_UNUSED, 32'h0000_0000, 1'b1, deqe_pkg::ST_OK, 32'h0, 1);
    add_directed(deqe_pkg::REQ_POP_FRONT, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h7FFF_FFFF, 0);
    add_directed(deqe_pkg::REQ_PUSH_BACK, 32'h5A5A_5A5A, 1'b0, deqe_pkg::ST_OK, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, deqe_pkg::ST_OK, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PEEK_FRONT, 32'h0000_0000, 1'b0, deqe_pkg::ST_OK, 32'h0, 0);
    add_directed(deqe_pkg::REQ_CLEAR, 32'h1234_5678, 1'b1, deqe_pkg::ST_OK, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PEEK_BACK, 32'h0000_0000, 1'b1, deqe_pkg::ST_EMPTY, 32'h0, 0);
    add_directed(deqe_pkg::REQ_PUSH_BACK, 32'h0000_0001, 1'b1, deqe_pkg::ST_OK, 32'h0, 1);
    add_directed(deqe_pkg::REQ_PEEK_FRONT, 32'h0, 1'b1, deqe_pkg::ST_OK, 32'h0000_0001, 1);
    add_directed(deqe_pkg::REQ_CLEAR, 32'h0000_0000, 1'b1, deqe_pkg::ST_OK, 32'h0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 20);

    for (int i = 0; i < directed_count; i++) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);
      pace(1'b0);
    end

    // Fill the empty queue from both ends, then push twice more against the full limit.
    for (int n = 0; n < DEPTH + 2; n++) begin
      w.req_type = $urandom_range(0, 1) ? deqe_pkg::REQ_PUSH_BACK : deqe_pkg::REQ_PUSH_FRONT;
      w.push_value = random_word();
      send_word(w, 1'b0, '0);
      pace(1'b0);
    end
    pace(1'b1);

    while (words_sent < TOTAL_WORDS) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(30, 150);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < seg_len && words_sent < TOTAL_WORDS; n++) begin
        send_word(random_request(mix), 1'b0, '0);
        pace(1'b0);
      end
      if ($urandom_range(0, 3) == 0)
        pace(1'b1);
    end
    req_valid <= 1'b0;

    while (results_pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d results: %0d full and %0d empty rejections,",
             words_sent, results_seen, full_rejects, empty_rejects);
    $display("peak occupancy %0d of %0d, %0d mismatching results", peak_count, DEPTH,
             mismatches);
    if (mismatches == 0 && results_pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
